// ===== rtl/core/rfpwc_pkg.sv =====
package rfpwc_pkg;

    // Field widths fixed by the interface
    localparam int PULSE_W   = 17;
    localparam int CODE_W    = 56;
    localparam int COUNT_W   = 6;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PULSE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PULSE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_PULSE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_GAP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 3'd4;

    // Register reset values, in microseconds
    localparam logic [PULSE_W-1:0] SHORT_PULSE_RST = 17'd500;
    localparam logic [PULSE_W-1:0] LONG_PULSE_RST  = 17'd1000;
    localparam logic [PULSE_W-1:0] SYNC_PULSE_RST  = 17'd11000;
    localparam logic [PULSE_W-1:0] RELEASE_GAP_RST = 17'd50000;
    localparam logic [PULSE_W-1:0] TOLERANCE_RST   = 17'd100;

    typedef struct packed {
        logic [PULSE_W-1:0] short_pulse_us;
        logic [PULSE_W-1:0] long_pulse_us;
        logic [PULSE_W-1:0] sync_pulse_us;
        logic [PULSE_W-1:0] release_gap_us;
        logic [PULSE_W-1:0] tolerance_us;
    } cfg_t;

    // Window hits for one pulse; priority is resolved by the assembler
    typedef struct packed {
        logic release_gap;
        logic sync;
        logic one_bit;
        logic zero_bit;
    } pulse_class_t;

endpackage

// ===== rtl/core/rfpwc_cfg_regs.sv =====
module rfpwc_cfg_regs
    import rfpwc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PULSE_W-1:0]   cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register write decode; unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SHORT_PULSE: cfg_next.short_pulse_us = cfg_data;
                REG_LONG_PULSE:  cfg_next.long_pulse_us  = cfg_data;
                REG_SYNC_PULSE:  cfg_next.sync_pulse_us  = cfg_data;
                REG_RELEASE_GAP: cfg_next.release_gap_us = cfg_data;
                REG_TOLERANCE:   cfg_next.tolerance_us   = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_pulse_us <= SHORT_PULSE_RST;
            cfg_reg.long_pulse_us  <= LONG_PULSE_RST;
            cfg_reg.sync_pulse_us  <= SYNC_PULSE_RST;
            cfg_reg.release_gap_us <= RELEASE_GAP_RST;
            cfg_reg.tolerance_us   <= TOLERANCE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/rfpwc_classify.sv =====
module rfpwc_classify
    import rfpwc_pkg::*;
(
    input  cfg_t               cfg,
    input  logic [PULSE_W-1:0] duration,
    output pulse_class_t       cls
);

    // One extra bit keeps every sum exact; lower bounds are tested as d + t
    // against the nominal so a window that reaches below zero needs no sign.
    logic [PULSE_W:0] dur_plus_tol;
    logic [PULSE_W:0] dur_ext;
    logic [PULSE_W:0] sync_hi;
    logic [PULSE_W:0] long_hi;
    logic [PULSE_W:0] short_hi;

    assign dur_ext      = {1'b0, duration};
    assign dur_plus_tol = dur_ext + {1'b0, cfg.tolerance_us};
    assign sync_hi      = {1'b0, cfg.sync_pulse_us} + {1'b0, cfg.tolerance_us};
    assign long_hi      = {1'b0, cfg.long_pulse_us} + {1'b0, cfg.tolerance_us};
    assign short_hi     = {1'b0, cfg.short_pulse_us} + {1'b0, cfg.tolerance_us};

    // Release: strictly above release gap minus tolerance
    assign cls.release_gap = dur_plus_tol > {1'b0, cfg.release_gap_us};

    // Sync window is open at both ends
    assign cls.sync = (dur_plus_tol > {1'b0, cfg.sync_pulse_us}) && (dur_ext < sync_hi);

    // Data windows are closed at both ends
    assign cls.one_bit  = (dur_plus_tol >= {1'b0, cfg.long_pulse_us}) && (dur_ext <= long_hi);
    assign cls.zero_bit = (dur_plus_tol >= {1'b0, cfg.short_pulse_us}) && (dur_ext <= short_hi);

endmodule

// ===== rtl/core/rfpwc_assembler.sv =====
module rfpwc_assembler
    import rfpwc_pkg::*;
#(
    parameter int CODE_BYTES = 7
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  pulse_class_t       cls,
    output logic [CODE_W-1:0]  code_value,
    output logic               code_valid,
    output logic               receiving,
    output logic [COUNT_W-1:0] bit_count,
    output logic               indicator
);

    localparam int CODE_BITS = CODE_BYTES * 8;
    localparam int CNT_W     = $clog2(CODE_BITS + 1);
    localparam int IDX_W     = CNT_W - 3;

    logic [7:0]          asm_reg [CODE_BYTES];
    logic [7:0]          asm_next [CODE_BYTES];
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [CODE_W-1:0]   code_reg;
    logic [CODE_W-1:0]   code_next;
    logic                flag_reg;
    logic                flag_next;
    logic                recv_reg;
    logic                recv_next;
    logic                led_reg;
    logic                led_next;
    logic [CODE_BITS-1:0] asm_flat;

    // First received byte lands in the most significant position
    always_comb
    begin
        for (int i = 0; i < CODE_BYTES; i++)
        begin
            asm_flat[CODE_BITS-1-8*i -: 8] = asm_reg[i];
        end
    end

    // Per-pulse state update, release over sync over data
    always_comb
    begin
        asm_next  = asm_reg;
        cnt_next  = cnt_reg;
        code_next = code_reg;
        flag_next = flag_reg;
        recv_next = recv_reg;
        led_next  = led_reg;
        if (advance)
        begin
            if (cls.release_gap)
            begin
                for (int i = 0; i < CODE_BYTES; i++)
                begin
                    asm_next[i] = '0;
                end
                cnt_next  = '0;
                recv_next = 1'b0;
                led_next  = 1'b0;
                flag_next = 1'b0;
            end
            else if (cls.sync)
            begin
                for (int i = 0; i < CODE_BYTES; i++)
                begin
                    asm_next[i] = '0;
                end
                cnt_next  = '0;
                recv_next = 1'b1;
                led_next  = 1'b1;
            end
            else if (recv_reg)
            begin
                if (cnt_reg >= CNT_W'(CODE_BITS))
                begin
                    // Full frame: capture and restart assembly
                    code_next = CODE_W'(asm_flat);
                    flag_next = 1'b1;
                    for (int i = 0; i < CODE_BYTES; i++)
                    begin
                        asm_next[i] = '0;
                    end
                    cnt_next = '0;
                end
                else
                begin
                    // Shift current byte; long wins over short on overlap
                    for (int i = 0; i < CODE_BYTES; i++)
                    begin
                        if (cnt_reg[CNT_W-1:3] == IDX_W'(i))
                        begin
                            asm_next[i] = {asm_reg[i][6:0], cls.one_bit};
                        end
                    end
                    if (cls.one_bit || cls.zero_bit)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
        end
    end

    // Assembly bytes are payload and need no reset value beyond clearing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CODE_BYTES; i++)
            begin
                asm_reg[i] <= '0;
            end
            cnt_reg  <= '0;
            code_reg <= '0;
            flag_reg <= 1'b0;
            recv_reg <= 1'b0;
            led_reg  <= 1'b0;
        end
        else
        begin
            asm_reg  <= asm_next;
            cnt_reg  <= cnt_next;
            code_reg <= code_next;
            flag_reg <= flag_next;
            recv_reg <= recv_next;
            led_reg  <= led_next;
        end
    end

    assign code_value = code_reg;
    assign code_valid = flag_reg;
    assign receiving  = recv_reg;
    assign bit_count  = COUNT_W'(cnt_reg);
    assign indicator  = led_reg;

endmodule

// ===== rtl/core/rf_pulse_width_code_receiver_unit.sv =====
// Pulse-width code receiver for a 433 MHz OOK link.
// Input channel (in_valid/in_ready/pulse_duration): one edge-to-edge duration
// in microseconds per transfer. Output channel (out_valid/out_ready): one
// status transfer per input, carrying the captured code, its valid flag, the
// receiving flag, the assembled bit count and the LED drive, all as they stand
// after that pulse.
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (0 short, 1 long, 2 sync, 3 release gap, 4 tolerance); write only while idle.
// Latency: a pulse held in the input register is decoded into the state/result
// registers once the result slot is free; its result is presented from then on.
// Throughput: one pulse per cycle while out_ready holds high, set by the
// single decode stage between the input register and the state/result registers.
// Stall: while out_ready is low the result holds; the input register still
// takes one more pulse, then in_ready drops until the result is transferred.
// Reset: config returns to its defaults, all state and flags clear, both
// channels empty.
module rf_pulse_width_code_receiver_unit
    import rfpwc_pkg::*;
#(
    parameter int CODE_BYTES = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PULSE_W-1:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PULSE_W-1:0]   pulse_duration,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CODE_W-1:0]    code_value,
    output logic                 code_valid,
    output logic                 receiving,
    output logic [COUNT_W-1:0]   bit_count,
    output logic                 indicator
);

    cfg_t               cfg;
    pulse_class_t       cls;
    logic               in_full_reg;
    logic               in_full_next;
    logic [PULSE_W-1:0] dur_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               advance;

    rfpwc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Process the held pulse when the result slot is free or being emptied
    assign advance  = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_full_reg || advance;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_valid && in_ready)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Input register and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Duration payload, loaded on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            dur_reg <= pulse_duration;
        end
    end

    rfpwc_classify u_classify (
        .cfg      (cfg),
        .duration (dur_reg),
        .cls      (cls)
    );

    rfpwc_assembler #(
        .CODE_BYTES (CODE_BYTES)
    ) u_assembler (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .cls        (cls),
        .code_value (code_value),
        .code_valid (code_valid),
        .receiving  (receiving),
        .bit_count  (bit_count),
        .indicator  (indicator)
    );

    assign out_valid = out_valid_reg;

endmodule
